>>> hw/rtl/css_pkg.sv
`default_nettype none

package css_pkg;

    // Default frame size limits; the top level hands these down as parameters.
    localparam int unsigned MAX_WIDTH_DEF  = 4096;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned SUM_W      = 9;
    localparam int unsigned LB_DATA_W  = 2 * SUM_W;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned SIZE_W     = CFG_DATA_W + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Chroma mode codes; the unused code behaves as pass-through.
    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_422  = 2'd1;
    localparam logic [1:0] MODE_420  = 2'd2;

    // What an accepted pixel does once it reaches the compute stage.
    typedef enum logic [2:0] {
        K_NONE,
        K_PASS,
        K_AVG2,
        K_STORE,
        K_AVG4
    } t_kind;

    // Index of the last pixel of a dimension: zero reads as one, and a size
    // above the limit saturates to the limit.
    function automatic logic [SIZE_W-1:0] clamp_last(
        input logic [CFG_DATA_W-1:0] size,
        input logic [SIZE_W-1:0]     max_size
    );
        logic [SIZE_W-1:0] ext;
        ext = {1'b0, size};
        if (ext == '0) begin
            return '0;
        end else if (ext > max_size) begin
            return max_size - SIZE_W'(1);
        end else begin
            return ext - SIZE_W'(1);
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/css_line_buf.sv
`default_nettype none

module css_line_buf
    import css_pkg::*;
#(
    parameter int unsigned DEPTH = (MAX_WIDTH_DEF + 1) / 2,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rd_en,
    input  wire logic [AW-1:0]        i_rd_addr,
    output logic      [LB_DATA_W-1:0] o_rd_data,
    input  wire logic                 i_wr_en,
    input  wire logic [AW-1:0]        i_wr_addr,
    input  wire logic [LB_DATA_W-1:0] i_wr_data
);

    logic [LB_DATA_W-1:0] r_mem [DEPTH];
    logic [LB_DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A write in the same cycle to the same entry is forwarded; the forwarded
    // data is only ever used for a one-pixel-wide frame.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hw/rtl/chroma_subsampler_444_top.sv
// Path: an accepted pixel is registered in the compute stage, then in the output register,
// from which it leaves as a transaction. Throughput: one pixel per clock unless the sink
// stalls; the line buffer read and write ports sustain it.
// Results: every pixel in 4:4:4, one per pair in 4:2:2, one per 2x2 block in 4:2:0.
// Reset (i_rst_n low, synchronous): mode 4:4:4, frame 1x1, position and pipeline
// cleared; the line buffer is not cleared and needs no clearing pass.
`default_nettype none

module chroma_subsampler_444_top
    import css_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Pixel input. tdata: u_in [7:0], v_in [15:8].
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,

    // Chroma output. tdata: u_out [7:0], v_out [15:8].
    // tlast: row_end. tuser: frame_end [0].
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [15:0]                m_axis_tdata,
    output logic                       m_axis_tlast,
    output logic [0:0]                 m_axis_tuser,

    // Configuration writes: index 0 chroma_mode, 1 frame_width, 2 frame_height.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Position counter widths follow the frame limits; the line buffer holds one
    // pair sum per two columns.
    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);
    localparam int unsigned LD = (MAX_WIDTH + 1) / 2;
    localparam int unsigned AW = (LD > 1) ? $clog2(LD) : 1;

    // ------------------------------------------------------------------
    // Configuration. The port is always ready; writes must only arrive
    // while the block is idle, which the block itself does not enforce.
    // The size registers keep the index of the last column and row after
    // clamping, so the counters compare for equality.
    // ------------------------------------------------------------------
    logic [1:0]    r_mode;
    logic [CW-1:0] r_wlast;
    logic [RW-1:0] r_hlast;
    logic          cfg_acc;
    logic          cfg_restart;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign cfg_restart = cfg_acc && ((i_cfg_index == CFG_MODE) ||
                                     (i_cfg_index == CFG_WIDTH) ||
                                     (i_cfg_index == CFG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PASS;
            r_wlast <= '0;
            r_hlast <= '0;
        end else if (cfg_acc) begin
            if (i_cfg_index == CFG_MODE) begin
                r_mode <= i_cfg_data[1:0];
            end
            if (i_cfg_index == CFG_WIDTH) begin
                r_wlast <= CW'(clamp_last(i_cfg_data, SIZE_W'(MAX_WIDTH)));
            end
            if (i_cfg_index == CFG_HEIGHT) begin
                r_hlast <= RW'(clamp_last(i_cfg_data, SIZE_W'(MAX_HEIGHT)));
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The compute stage holds at most one pixel and the output
    // register one result, so a new pixel is taken while a finished result
    // still waits for the sink, unless the compute stage holds another result.
    // Pixels that only fill the line buffer leave the compute stage without needing the output register.
    // ------------------------------------------------------------------
    logic          r_s1_valid;
    t_kind         r_s1_kind;
    logic          r_o_valid;
    logic          out_can;
    logic          s1_emits;
    logic          s1_go;
    logic          in_acc;

    assign out_can       = !r_o_valid || m_axis_tready;
    assign s1_emits      = (r_s1_kind != K_STORE);
    assign s1_go         = r_s1_valid && (!s1_emits || out_can);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Position tracking and classification of the incoming pixel. The
    // counters and the held first sample of a horizontal pair move on at
    // the edge that accepts the pixel.
    // ------------------------------------------------------------------
    logic [CW-1:0]       r_col;
    logic [RW-1:0]       r_row;
    logic [SAMPLE_W-1:0] r_held_u;
    logic [SAMPLE_W-1:0] r_held_v;
    logic [SAMPLE_W-1:0] in_u;
    logic [SAMPLE_W-1:0] in_v;
    logic                last_col;
    logic                last_row;
    logic                first_of_pair;
    logic                subsample;
    t_kind               n_kind;

    assign in_u          = s_axis_tdata[7:0];
    assign in_v          = s_axis_tdata[15:8];
    assign last_col      = (r_col == r_wlast);
    assign last_row      = (r_row == r_hlast);
    assign first_of_pair = !r_col[0];
    assign subsample     = (r_mode == MODE_422) || (r_mode == MODE_420);

    // A lone last column pairs with itself. A lone last even row in 4:2:0
    // averages its pair with itself, which reduces to the horizontal average.
    always_comb begin
        priority if (!subsample) begin
            n_kind = K_PASS;
        end else if (first_of_pair && !last_col) begin
            n_kind = K_NONE;
        end else if (r_mode == MODE_422) begin
            n_kind = K_AVG2;
        end else if (!r_row[0] && last_row) begin
            n_kind = K_AVG2;
        end else if (!r_row[0]) begin
            n_kind = K_STORE;
        end else begin
            n_kind = K_AVG4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_held_u <= '0;
            r_held_v <= '0;
        end else if (cfg_restart) begin
            r_col    <= '0;
            r_row    <= '0;
            r_held_u <= '0;
            r_held_v <= '0;
        end else if (in_acc) begin
            if (n_kind == K_NONE) begin
                r_held_u <= in_u;
                r_held_v <= in_v;
            end
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Compute stage registers. The partner sample is the held one, or the
    // pixel itself when an odd last column closes a pair alone.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] r_s1_u;
    logic [SAMPLE_W-1:0] r_s1_v;
    logic [SAMPLE_W-1:0] r_s1_pu;
    logic [SAMPLE_W-1:0] r_s1_pv;
    logic [AW-1:0]       r_s1_addr;
    logic                r_s1_row_end;
    logic                r_s1_frame_end;
    logic [AW-1:0]       rd_addr;

    assign rd_addr = AW'(r_col >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_kind  <= K_NONE;
        end else if (in_acc) begin
            r_s1_valid <= (n_kind != K_NONE);
            r_s1_kind  <= n_kind;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_u         <= in_u;
            r_s1_v         <= in_v;
            r_s1_pu        <= first_of_pair ? in_u : r_held_u;
            r_s1_pv        <= first_of_pair ? in_v : r_held_v;
            r_s1_addr      <= rd_addr;
            r_s1_row_end   <= last_col;
            r_s1_frame_end <= last_col && last_row;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer: even rows write their pair sums, odd rows read them
    // back. The read is issued when the pixel is accepted, so its data is
    // registered alongside the compute stage.
    // ------------------------------------------------------------------
    logic [LB_DATA_W-1:0] lb_rd_data;
    logic [LB_DATA_W-1:0] lb_wr_data;
    logic                 lb_wr_en;
    logic [SUM_W-1:0]     sum_u;
    logic [SUM_W-1:0]     sum_v;

    assign sum_u      = {1'b0, r_s1_pu} + {1'b0, r_s1_u};
    assign sum_v      = {1'b0, r_s1_pv} + {1'b0, r_s1_v};
    assign lb_wr_data = {sum_v, sum_u};
    assign lb_wr_en   = s1_go && (r_s1_kind == K_STORE);

    css_line_buf #(
        .DEPTH (LD),
        .AW    (AW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (lb_rd_data),
        .i_wr_en   (lb_wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (lb_wr_data)
    );

    // ------------------------------------------------------------------
    // Averaging: round-half-up of a pair, or of a pair plus the stored
    // pair sum from the row above.
    // ------------------------------------------------------------------
    logic [SUM_W:0]      avg2_u;
    logic [SUM_W:0]      avg2_v;
    logic [SUM_W:0]      avg4_u;
    logic [SUM_W:0]      avg4_v;
    logic [SAMPLE_W-1:0] n_o_u;
    logic [SAMPLE_W-1:0] n_o_v;

    assign avg2_u = {1'b0, sum_u} + (SUM_W + 1)'(1);
    assign avg2_v = {1'b0, sum_v} + (SUM_W + 1)'(1);
    assign avg4_u = {1'b0, lb_rd_data[SUM_W-1:0]} + {1'b0, sum_u} + (SUM_W + 1)'(2);
    assign avg4_v = {1'b0, lb_rd_data[LB_DATA_W-1:SUM_W]} + {1'b0, sum_v}
                    + (SUM_W + 1)'(2);

    always_comb begin
        unique case (r_s1_kind)
            K_AVG2: begin
                n_o_u = avg2_u[SAMPLE_W:1];
                n_o_v = avg2_v[SAMPLE_W:1];
            end
            K_AVG4: begin
                n_o_u = avg4_u[SUM_W:2];
                n_o_v = avg4_v[SUM_W:2];
            end
            default: begin
                n_o_u = r_s1_u;
                n_o_v = r_s1_v;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] r_o_u;
    logic [SAMPLE_W-1:0] r_o_v;
    logic                r_o_row_end;
    logic                r_o_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_go && s1_emits) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_emits) begin
            r_o_u         <= n_o_u;
            r_o_v         <= n_o_v;
            r_o_row_end   <= r_s1_row_end;
            r_o_frame_end <= r_s1_frame_end;
        end
    end

    assign m_axis_tvalid   = r_o_valid;
    assign m_axis_tdata    = {r_o_v, r_o_u};
    assign m_axis_tlast    = r_o_row_end;
    assign m_axis_tuser[0] = r_o_frame_end;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The input only stalls while the compute stage is occupied.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_valid)
        else $error("input stalled with an empty compute stage");

    // The column counter never runs past the last column of the frame.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_wlast)
        else $error("column counter beyond the frame width");

    // The end of a frame is always the end of a row.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("frame end without row end");

    // A pixel that only fills the line buffer never reaches the output.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lb_wr_en && !(r_o_valid && !m_axis_tready) |=> !r_o_valid)
        else $error("line buffer write produced an output transaction");

endmodule

`default_nettype wire
